// File: rtl/stereo_allpass_diffuser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo allpass diffuser
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_ALLPASS_DIFFUSER_ASSERT_SVH
`define STEREO_ALLPASS_DIFFUSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sad_pkg.sv
// ----------------------------------------------------------------------------
// Stereo allpass diffuser package
// Shared constants, types and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

   localparam int RING_LENGTH = 4096;
   localparam int POS_BITS    = $clog2(RING_LENGTH);
   localparam int STAGE_COUNT = 4;
   localparam int STAGE_BITS  = $clog2(STAGE_COUNT);
   localparam int ADDR_BITS   = STAGE_BITS + POS_BITS;
   localparam int MEM_DEPTH   = STAGE_COUNT * RING_LENGTH;

   localparam int SAMPLE_BITS = 24;
   localparam int WORD_BITS   = SAMPLE_BITS + 4;
   localparam int AMT_BITS    = 16;
   localparam int DELAY_BITS  = 12;
   localparam int DELAY_REGS  = 4;
   localparam int REG_BITS    = $clog2(DELAY_REGS);

   localparam int REQ_BITS = 2 * SAMPLE_BITS + AMT_BITS;
   localparam int RSP_BITS = 2 * SAMPLE_BITS;

   localparam int AMOUNT_ONE   = 32768;
   localparam int BYPASS_BELOW = 33;
   localparam int RIGHT_OFFSET = 7;

   // Cross amount is round(0.3 * amount) = floor((3 * amount + 5) / 10); the
   // divide by ten is a multiply by ceil(2^20 / 10) and a shift.
   localparam int CROSS_MUL   = 3;
   localparam int CROSS_ADD   = 5;
   localparam int CROSS_RECIP = 104858;
   localparam int CROSS_SHIFT = 20;

   // Blend arithmetic widths.
   localparam int BLEND_SHIFT = 15;
   localparam int PROD_BITS   = WORD_BITS + AMT_BITS + 2;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int MIX_BITS    = SUM_BITS - BLEND_SHIFT;

   localparam longint WORD_MAX   = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam longint WORD_MIN   = -WORD_MAX - 64'sd1;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DELAY_BITS-1:0]         delay_type;
   typedef logic [AMT_BITS-1:0]           amount_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

   localparam delay_type DELAY_RESET [DELAY_REGS] = '{
      DELAY_BITS'(1631), DELAY_BITS'(1896), DELAY_BITS'(2337), DELAY_BITS'(2690)
   };

   typedef struct packed {
      logic go;           // capture new products this cycle
      logic final_blend;  // wet/dry blend, saturates to the sample width
   } mix_ctl_type;

   function automatic word_type sat_word(input logic signed [MIX_BITS-1:0] x);
      word_type r;
      if (x > WORD_MAX) begin
         r = WORD_BITS'(WORD_MAX);
      end else if (x < WORD_MIN) begin
         r = WORD_BITS'(WORD_MIN);
      end else begin
         r = x[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_sample(input logic signed [MIX_BITS-1:0] x);
      sample_type r;
      if (x > SAMPLE_MAX) begin
         r = SAMPLE_BITS'(SAMPLE_MAX);
      end else if (x < SAMPLE_MIN) begin
         r = SAMPLE_BITS'(SAMPLE_MIN);
      end else begin
         r = x[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sad_ring_mem.sv
// ----------------------------------------------------------------------------
// Delay ring memory
// All stage rings of one channel, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_ring_mem
   import sad_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     wr_en,
   input  wire addr_type wr_addr,
   input  wire word_type wr_data,
   input  wire logic     rd_en,
   input  wire addr_type rd_addr,
   output word_type      rd_data
);

   word_type mem [MEM_DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/sad_mix_unit.sv
// ----------------------------------------------------------------------------
// Blend unit
// Computes a*(1-k) + b*k for both channels from registered products, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_mix_unit
   import sad_pkg::*;
(
   input  wire logic        clock,
   input  wire mix_ctl_type ctl,
   input  wire word_type    a_l,
   input  wire word_type    b_l,
   input  wire word_type    a_r,
   input  wire word_type    b_r,
   input  wire amount_type  k,
   output word_type         w_l,
   output word_type         w_r
);

   localparam int ROUND_HALF = 1 << (BLEND_SHIFT - 1);

   // a*(ONE-k) + b*k is rewritten as a*ONE + (b-a)*k, one product per channel.
   logic signed [WORD_BITS:0]     diff_l, diff_r;
   logic signed [AMT_BITS:0]      k_s;
   logic signed [PROD_BITS-1:0]   prod_l_in, prod_r_in;
   logic signed [PROD_BITS-1:0]   prod_l_ff, prod_r_ff;
   word_type                      base_l_ff, base_r_ff;
   logic                          final_ff;
   logic signed [SUM_BITS-1:0]    sum_l, sum_r;
   logic signed [MIX_BITS-1:0]    mix_l, mix_r;

   always_comb begin
      diff_l    = (WORD_BITS+1)'(b_l) - (WORD_BITS+1)'(a_l);
      diff_r    = (WORD_BITS+1)'(b_r) - (WORD_BITS+1)'(a_r);
      k_s       = signed'({1'b0, k});
      prod_l_in = PROD_BITS'(diff_l * k_s);
      prod_r_in = PROD_BITS'(diff_r * k_s);
   end

   always_ff @(posedge clock) begin
      if (ctl.go) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         base_l_ff <= a_l;
         base_r_ff <= a_r;
         final_ff  <= ctl.final_blend;
      end
   end

   always_comb begin
      sum_l = SUM_BITS'(prod_l_ff) + (SUM_BITS'(base_l_ff) <<< BLEND_SHIFT)
              + SUM_BITS'(ROUND_HALF);
      sum_r = SUM_BITS'(prod_r_ff) + (SUM_BITS'(base_r_ff) <<< BLEND_SHIFT)
              + SUM_BITS'(ROUND_HALF);
      mix_l = signed'(sum_l[SUM_BITS-1:BLEND_SHIFT]);
      mix_r = signed'(sum_r[SUM_BITS-1:BLEND_SHIFT]);
      w_l   = final_ff ? WORD_BITS'(sat_sample(mix_l)) : sat_word(mix_l);
      w_r   = final_ff ? WORD_BITS'(sat_sample(mix_r)) : sat_word(mix_r);
   end

endmodule

`default_nettype wire

// File: rtl/stereo_allpass_diffuser.sv
// ----------------------------------------------------------------------------
// Stereo allpass diffuser
// Four cross-mixed Schroeder allpass stages per channel, blended with dry.
// ----------------------------------------------------------------------------
// Usage:
// A stereo pair and a mix amount arrive as one beat on the req_ channel; the
// diffused pair leaves as one beat on the rsp_ channel. The csr_ port sets the
// left delay of each stage; the right delay is seven samples longer.
// A diffused pair runs through the AP, MUL and SUM states for each stage in
// turn, then through FMUL and FSUM; a bypassed pair (amount under 33) runs
// through BYP alone. rsp_tvalid is set when FSUM or BYP loads the output
// register. One pair is worked on at a time, so a new beat is taken only in
// the idle state, once the pair before has left its last step. In each
// stage, AP does the delay memory read-modify-write and MUL and SUM do the
// cross-mix multiply and round; FMUL and FSUM do the final wet/dry blend.
// The result sits in an output register, so the next request is accepted
// while a result still waits; if the receiver stalls, the following item
// holds in its last step until the output register is free.
// Reset returns the delay registers to their defaults, the ring position to
// zero and drops rsp_tvalid. The delay memories are not swept: a fill flag
// marks ring entries not yet written since reset, and they read as zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_allpass_diffuser_assert.svh"

module stereo_allpass_diffuser
   import sad_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request: left_in [23:0], right_in [47:24], mix_amount [63:48]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_BITS-1:0]   req_tdata,
   // Response: left_out [23:0], right_out [47:24]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_BITS-1:0]        rsp_tdata,
   // Delay register writes
   input  wire logic                  csr_we,
   input  wire logic [REG_BITS-1:0]   csr_addr,
   input  wire logic [DELAY_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYP,
      ST_AP,
      ST_MUL,
      ST_SUM,
      ST_FMUL,
      ST_FSUM
   } state_type;

   localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(STAGE_COUNT - 1);
   localparam logic [POS_BITS-1:0]   LAST_POS   = POS_BITS'(RING_LENGTH - 1);

   state_type               state_ff, state_in;
   delay_type               cfg_delay_ff [DELAY_REGS];
   logic [STAGE_BITS-1:0]   stage_ff;
   logic [POS_BITS-1:0]     wp_ff;
   logic                    wrapped_ff;
   sample_type              dry_l_ff, dry_r_ff;
   amount_type              amt_ff, cross_ff;
   word_type                wl_ff, wr_ff, yl_ff, yr_ff;
   logic                    rd_ok_l_ff, rd_ok_r_ff;
   logic                    rsp_tvalid_ff;
   sample_type              rsp_l_ff, rsp_r_ff;

   // Input beat decode.
   logic                    accept, bypass, out_free;
   sample_type              in_l, in_r;
   amount_type              amt_raw, amt_sat;

   // Read address generation.
   logic [STAGE_BITS-1:0]   rd_stage;
   delay_type               reg_delay;
   logic [DELAY_BITS:0]     dl, dr_raw, dr;
   logic [POS_BITS-1:0]     rd_pos_l, rd_pos_r;
   logic                    ok_l, ok_r, rd_en, wr_en;
   addr_type                rd_addr_l, rd_addr_r, wr_addr;

   // Allpass datapath.
   word_type                mem_l_q, mem_r_q, del_l, del_r;
   logic signed [WORD_BITS:0] dif_l, dif_r, inc_l, inc_r, half_l, half_r, acc_l, acc_r;
   word_type                y_l, y_r, st_l, st_r;

   // Cross amount and blend unit.
   logic [AMT_BITS:0]       cross_num;
   logic [2*AMT_BITS+1:0]   cross_prod;
   mix_ctl_type             mix_ctl;
   word_type                mix_a_l, mix_b_l, mix_a_r, mix_b_r, mix_w_l, mix_w_r;
   amount_type              mix_k;

   always_comb begin
      in_l     = req_tdata[SAMPLE_BITS-1:0];
      in_r     = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      amt_raw  = req_tdata[REQ_BITS-1:2*SAMPLE_BITS];
      amt_sat  = (amt_raw > AMT_BITS'(AMOUNT_ONE)) ? AMT_BITS'(AMOUNT_ONE) : amt_raw;
      bypass   = amt_raw < AMT_BITS'(BYPASS_BELOW);
      req_tready = (state_ff == ST_IDLE);
      accept   = req_tvalid && req_tready;
      out_free = !rsp_tvalid_ff || rsp_tready;
   end

   // The first stage's read goes out with the request beat; each later stage's
   // read goes out in the last cycle of the stage before it.
   always_comb begin
      rd_stage  = (state_ff == ST_IDLE) ? '0 : stage_ff + 1'b1;
      reg_delay = cfg_delay_ff[rd_stage];
      dl        = (reg_delay == '0) ? (DELAY_BITS+1)'(1) : {1'b0, reg_delay};
      dr_raw    = dl + (DELAY_BITS+1)'(RIGHT_OFFSET);
      dr        = (dr_raw > (DELAY_BITS+1)'(RING_LENGTH)) ? (DELAY_BITS+1)'(RING_LENGTH)
                                                           : dr_raw;
      // A delay of the full ring length lands on the write position itself,
      // which is read before this item writes it.
      rd_pos_l  = wp_ff - dl[POS_BITS-1:0];
      rd_pos_r  = wp_ff - dr[POS_BITS-1:0];
      // Entries behind the write position, or any entry once the ring has
      // wrapped, have been written since reset.
      ok_l      = wrapped_ff || (rd_pos_l < wp_ff);
      ok_r      = wrapped_ff || (rd_pos_r < wp_ff);
      rd_en     = (accept && !bypass) || (state_ff == ST_SUM && stage_ff != LAST_STAGE);
      rd_addr_l = {rd_stage, rd_pos_l};
      rd_addr_r = {rd_stage, rd_pos_r};
      wr_en     = (state_ff == ST_AP);
      wr_addr   = {stage_ff, wp_ff};
   end

   sad_ring_mem u_left_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (st_l),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_l),
      .rd_data (mem_l_q)
   );

   sad_ring_mem u_right_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (st_r),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_r),
      .rd_data (mem_r_q)
   );

   // Allpass with gain one half: out = delayed - x, stored = x + delayed/2,
   // where the half rounds up on ties.
   always_comb begin
      del_l  = rd_ok_l_ff ? mem_l_q : '0;
      del_r  = rd_ok_r_ff ? mem_r_q : '0;
      dif_l  = (WORD_BITS+1)'(del_l) - (WORD_BITS+1)'(wl_ff);
      dif_r  = (WORD_BITS+1)'(del_r) - (WORD_BITS+1)'(wr_ff);
      inc_l  = (WORD_BITS+1)'(del_l) + 1'b1;
      inc_r  = (WORD_BITS+1)'(del_r) + 1'b1;
      half_l = inc_l >>> 1;
      half_r = inc_r >>> 1;
      acc_l  = (WORD_BITS+1)'(wl_ff) + half_l;
      acc_r  = (WORD_BITS+1)'(wr_ff) + half_r;
      y_l    = sat_word(MIX_BITS'(dif_l));
      y_r    = sat_word(MIX_BITS'(dif_r));
      st_l   = sat_word(MIX_BITS'(acc_l));
      st_r   = sat_word(MIX_BITS'(acc_r));
   end

   // The blend unit serves the cross-mix after each stage and the final
   // wet/dry blend.
   always_comb begin
      cross_num  = (AMT_BITS+1)'(CROSS_MUL) * (AMT_BITS+1)'(amt_ff)
                   + (AMT_BITS+1)'(CROSS_ADD);
      cross_prod = (2*AMT_BITS+2)'(cross_num) * (2*AMT_BITS+2)'(CROSS_RECIP);
      mix_ctl.go          = (state_ff == ST_MUL) || (state_ff == ST_FMUL);
      mix_ctl.final_blend = (state_ff == ST_FMUL);
      if (state_ff == ST_FMUL) begin
         mix_a_l = WORD_BITS'(dry_l_ff);
         mix_b_l = wl_ff;
         mix_a_r = WORD_BITS'(dry_r_ff);
         mix_b_r = wr_ff;
         mix_k   = amt_ff;
      end else begin
         mix_a_l = yl_ff;
         mix_b_l = yr_ff;
         mix_a_r = yr_ff;
         mix_b_r = yl_ff;
         mix_k   = cross_ff;
      end
   end

   sad_mix_unit u_mix (
      .clock (clock),
      .ctl   (mix_ctl),
      .a_l   (mix_a_l),
      .b_l   (mix_b_l),
      .a_r   (mix_a_r),
      .b_r   (mix_b_r),
      .k     (mix_k),
      .w_l   (mix_w_l),
      .w_r   (mix_w_r)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = bypass ? ST_BYP : ST_AP;
            end
         end
         ST_BYP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_AP:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = (stage_ff == LAST_STAGE) ? ST_FMUL : ST_AP;
         ST_FMUL: state_in = ST_FSUM;
         ST_FSUM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stage_ff      <= '0;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < DELAY_REGS; i++) begin
            cfg_delay_ff[i] <= DELAY_RESET[i];
         end
      end else begin
         state_ff <= state_in;
         cross_ff <= AMT_BITS'(cross_prod >> CROSS_SHIFT);
         if (csr_we) begin
            cfg_delay_ff[csr_addr] <= csr_wdata;
         end
         // A finishing step reloads the output register in the same cycle.
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_FSUM && state_ff != ST_BYP) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (accept) begin
            dry_l_ff <= in_l;
            dry_r_ff <= in_r;
            amt_ff   <= amt_sat;
            wl_ff    <= WORD_BITS'(in_l);
            wr_ff    <= WORD_BITS'(in_r);
            stage_ff <= '0;
         end
         if (rd_en) begin
            rd_ok_l_ff <= ok_l;
            rd_ok_r_ff <= ok_r;
         end
         if (state_ff == ST_AP) begin
            yl_ff <= y_l;
            yr_ff <= y_r;
         end
         if (state_ff == ST_SUM) begin
            wl_ff <= mix_w_l;
            wr_ff <= mix_w_r;
            if (stage_ff != LAST_STAGE) begin
               stage_ff <= stage_ff + 1'b1;
            end
         end
         if (state_ff == ST_FSUM && out_free) begin
            rsp_l_ff      <= mix_w_l[SAMPLE_BITS-1:0];
            rsp_r_ff      <= mix_w_r[SAMPLE_BITS-1:0];
            rsp_tvalid_ff <= 1'b1;
            wp_ff         <= wp_ff + 1'b1;
            if (wp_ff == LAST_POS) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (state_ff == ST_BYP && out_free) begin
            rsp_l_ff      <= dry_l_ff;
            rsp_r_ff      <= dry_r_ff;
            rsp_tvalid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_r_ff, rsp_l_ff};

   `SAD_ASSERT_IMPL(a_ap_after_read, clock, reset, state_ff == ST_AP, $past(rd_en), "allpass step without a memory read in the cycle before")
   `SAD_ASSERT_NEXT(a_wrap_sticky, clock, reset, wrapped_ff, wrapped_ff, "ring fill flag cleared outside reset")
   `SAD_ASSERT_NEXT(a_wp_step, clock, reset, state_ff == ST_FSUM && out_free, wp_ff == $past(wp_ff) + 1'b1, "ring position did not advance by one")
   `SAD_ASSERT_NEXT(a_bypass_holds, clock, reset, accept && bypass, $stable(wp_ff) && $stable(wrapped_ff), "bypassed pair moved the ring state")
   `SAD_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_FSUM || $past(state_ff) == ST_BYP, "response raised outside a finishing step")

endmodule

`default_nettype wire

// File: test/tb_stereo_allpass_diffuser.sv
// ----------------------------------------------------------------------------
// Stereo allpass diffuser testbench
// Streams stereo pairs with mix amounts into the diffuser, predicts every
// diffused pair with a behavioral copy of the four cross-mixed allpass stages,
// and compares each result beat in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_stereo_allpass_diffuser;
   import sad_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes of the csr_ port.
   typedef enum logic [REG_BITS-1:0] {
      REG_FIRST_DELAY  = 0,
      REG_SECOND_DELAY = 1,
      REG_THIRD_DELAY  = 2,
      REG_FOURTH_DELAY = 3
   } delay_reg_type;

   // Ways in which the receiver drops rsp_tready.
   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } diffused_pair_type;

   localparam int RESET_CYCLES  = 7;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [REG_BITS-1:0]   csr_addr   = '0;
   logic [DELAY_BITS-1:0] csr_wdata  = '0;

   // The checker pops from the front, the sender pushes to the back.
   diffused_pair_type pairs_due[$];
   int                fail_count  = 0;
   int                cycle_count = 0;

   // Sender burst control: a burst of beats, then a gap with tvalid low.
   bit gaps_on    = 1'b1;
   int burst_left = 0;

   // Receiver control. The long hold is requested by flipping hold_toggle so
   // that only the receiver process ever writes its own countdown.
   rx_pattern_type rx_pattern  = RX_ALWAYS;
   logic           hold_toggle = 1'b0;
   logic           hold_seen   = 1'b0;
   int             hold_left   = 0;
   int             rx_phase    = 0;

   // Predictor state: one ring per stage and channel, the shared write
   // position and the delay settings as last written.
   longint    delay_ring [2][MEM_DEPTH];
   int        write_pos;
   delay_type delay_setting [DELAY_REGS];

   stereo_allpass_diffuser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // left_in [23:0], right_in [47:24], mix_amount [63:48]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // left_out [23:0], right_out [47:24]
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint clip(input longint value, input int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (value > hi) begin
         return hi;
      end else if (value < lo) begin
         return lo;
      end
      return value;
   endfunction

   // a * (1 - k) + b * k in Q1.15, rounded half up; the arithmetic shift of
   // a signed longint is a floor.
   function automatic longint blend_q15(input longint a, input longint b, input longint k);
      return (a * (AMOUNT_ONE - k) + b * k + 64'sd16384) >>> BLEND_SHIFT;
   endfunction

   function automatic int clamp_delay(input int span);
      if (span < 1) begin
         return 1;
      end else if (span > RING_LENGTH) begin
         return RING_LENGTH;
      end
      return span;
   endfunction

   function automatic void clear_model();
      foreach (delay_ring[ch, idx]) begin
         delay_ring[ch][idx] = 0;
      end
      write_pos = 0;
      foreach (delay_setting[i]) begin
         delay_setting[i] = DELAY_RESET[i];
      end
   endfunction

   // Works out the diffused pair for one accepted beat and moves the rings.
   function automatic diffused_pair_type diffuse_pair(input sample_type dry_left,
                                                      input sample_type dry_right,
                                                      input amount_type amount);
      diffused_pair_type result;
      longint            amt;
      longint            cross_k;
      longint            delayed;
      longint            wet [2];
      longint            tap [2];
      int                span;
      int                rd;
      int                base;
      amt = amount;
      // Amounts above one are treated as one.
      if (amt > AMOUNT_ONE) begin
         amt = AMOUNT_ONE;
      end
      // Bypass: the pair passes bit for bit and no state moves.
      if (amt < BYPASS_BELOW) begin
         result.left  = dry_left;
         result.right = dry_right;
         return result;
      end
      cross_k = (3 * amt + 5) / 10;
      wet[0]  = dry_left;
      wet[1]  = dry_right;
      for (int s = 0; s < STAGE_COUNT; s++) begin
         base = s * RING_LENGTH;
         for (int ch = 0; ch < 2; ch++) begin
            // The right delay is seven longer, and both are clamped.
            span = clamp_delay(delay_setting[s % DELAY_REGS]);
            if (ch == 1) begin
               span = clamp_delay(span + RIGHT_OFFSET);
            end
            rd      = (write_pos + RING_LENGTH - span) % RING_LENGTH;
            delayed = delay_ring[ch][base + rd];
            tap[ch] = clip(delayed - wet[ch], WORD_BITS);
            delay_ring[ch][base + write_pos] =
               clip(wet[ch] + ((delayed + 64'sd1) >>> 1), WORD_BITS);
         end
         wet[0] = clip(blend_q15(tap[0], tap[1], cross_k), WORD_BITS);
         wet[1] = clip(blend_q15(tap[1], tap[0], cross_k), WORD_BITS);
      end
      write_pos    = (write_pos + 1) % RING_LENGTH;
      result.left  = sample_type'(clip(blend_q15(dry_left, wet[0], amt), SAMPLE_BITS));
      result.right = sample_type'(clip(blend_q15(dry_right, wet[1], amt), SAMPLE_BITS));
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------------

   // The receiver either sits out a requested long hold or follows the
   // current stall pattern.
   always @(posedge clock) begin
      rx_phase <= (rx_phase + 1) % 7;
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            RX_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            RX_PERIODIC: begin
               rsp_tready <= (rx_phase < 4);
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Every result beat is matched against the oldest prediction.
   always @(posedge clock) begin : check_beat
      diffused_pair_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pairs_due.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("unexpected result beat: left %0d right %0d",
                        $signed(rsp_tdata[SAMPLE_BITS-1:0]),
                        $signed(rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
            end
            fail_count++;
         end else begin
            due = pairs_due.pop_front();
            if (rsp_tdata[SAMPLE_BITS-1:0] !== due.left ||
                rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== due.right) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("mismatch: expected left %0d right %0d, got left %0d right %0d",
                           due.left, due.right,
                           $signed(rsp_tdata[SAMPLE_BITS-1:0]),
                           $signed(rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
               end
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender and register access
   // ---------------------------------------------------------------------

   // Offers one beat, waits for the handshake, records the prediction, and
   // closes the burst with a random gap when it runs out. If the burst goes
   // on, tvalid stays high for the caller's next beat.
   task automatic send_pair(input sample_type left_in, input sample_type right_in,
                            input amount_type amount);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {amount, right_in, left_in};
      do begin
         @(posedge clock);
      end while (!req_tready);
      pairs_due.insert(pairs_due.size(), diffuse_pair(left_in, right_in, amount));
      if (burst_left > 0) begin
         burst_left--;
      end
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(1, 20);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every predicted pair has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pairs_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_delay(input delay_reg_type index, input delay_type value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      delay_setting[index] = value;
      @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic set_delays(input delay_type d0, input delay_type d1,
                             input delay_type d2, input delay_type d3);
      write_delay(REG_FIRST_DELAY, d0);
      write_delay(REG_SECOND_DELAY, d1);
      write_delay(REG_THIRD_DELAY, d2);
      write_delay(REG_FOURTH_DELAY, d3);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Full-scale extremes, small values near zero, or any 24-bit word.
   function automatic sample_type pick_level();
      case ($urandom_range(0, 7))
         0:       return sample_type'(SAMPLE_MAX);
         1:       return sample_type'(SAMPLE_MIN);
         2:       return sample_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Random beats. Most amounts diffuse; some bypass, some exceed one, and
   // some sit right on the thresholds.
   task automatic run_random_pairs(input int count);
      amount_type amount;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0:       amount = amount_type'($urandom_range(0, BYPASS_BELOW - 1));
            1:       amount = amount_type'($urandom_range(AMOUNT_ONE + 1, 65535));
            2:       amount = $urandom_range(0, 1) ? amount_type'(AMOUNT_ONE)
                                                   : amount_type'(BYPASS_BELOW);
            default: amount = amount_type'($urandom_range(BYPASS_BELOW, AMOUNT_ONE));
         endcase
         send_pair(pick_level(), pick_level(), amount);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Zero, full-scale and mixed pairs through the delays left by reset; the
   // rings still read zero, so each allpass stage just negates its input.
   task automatic test_reset_defaults();
      send_pair('0, '0, amount_type'(AMOUNT_ONE));
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN), amount_type'(AMOUNT_ONE));
      send_pair(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MAX), amount_type'(16384));
      send_pair(sample_type'(1), sample_type'(-1), amount_type'(BYPASS_BELOW));
      send_pair(sample_type'(12345), sample_type'(-54321), amount_type'(65535));
      drain();
   endtask

   // Amounts around the bypass threshold and above one. Bypassed pairs must
   // come back bit for bit and must not move the ring position.
   task automatic test_bypass_threshold();
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN), '0);
      send_pair(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MAX), amount_type'(BYPASS_BELOW - 1));
      send_pair(sample_type'(-1), sample_type'(1), amount_type'(1));
      send_pair(sample_type'(24'h123456), sample_type'(24'hEDCBA9), amount_type'(BYPASS_BELOW));
      send_pair(sample_type'(24'h7F0F0F), sample_type'(24'h80F0F0), amount_type'(AMOUNT_ONE));
      send_pair(sample_type'(24'h555555), sample_type'(24'hAAAAAA), amount_type'(AMOUNT_ONE + 1));
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), amount_type'(65535));
      send_pair(sample_type'(24'h654321), sample_type'(24'h9ABCDE), amount_type'(31));
      drain();
   endtask

   // A zero delay clamps up to one, and left delays of 4090 and more push
   // the right delay past the ring, where it clamps to the full ring.
   task automatic test_delay_extremes();
      set_delays('0, delay_type'(4095), delay_type'(1), delay_type'(4090));
      repeat (3) begin
         send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), amount_type'(AMOUNT_ONE));
      end
      repeat (3) begin
         send_pair(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MIN), amount_type'(AMOUNT_ONE));
      end
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN), amount_type'(20000));
      send_pair('0, '0, amount_type'(BYPASS_BELOW));
      drain();
   endtask

   // Several delay settings, each followed by random beats under a random
   // stall pattern. The first runs with no idling on either side.
   task automatic test_random_sweep();
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin
               // Very short delays, so the feedback builds up quickly.
               set_delays(delay_type'(1), delay_type'(2), delay_type'(3), delay_type'(5));
            end
            1: begin
               set_delays(delay_type'(37), delay_type'(43), delay_type'(53), delay_type'(61));
            end
            2: begin
               set_delays(delay_type'(4095), delay_type'(4089), '0, delay_type'(4090));
            end
            3: begin
               set_delays(delay_type'($urandom_range(1, 64)), delay_type'($urandom_range(1, 64)),
                          delay_type'($urandom_range(1, 64)), delay_type'($urandom_range(1, 64)));
            end
            default: begin
               set_delays(delay_type'($urandom), delay_type'($urandom),
                          delay_type'($urandom), delay_type'($urandom));
            end
         endcase
         if (phase == 0) begin
            gaps_on    = 1'b0;
            rx_pattern <= RX_ALWAYS;
         end else begin
            gaps_on    = ($urandom_range(0, 3) != 0);
            rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
         end
         run_random_pairs(90);
      end
      drain();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the block fills and drops req_tready. Then the sender
   // pauses until everything is back before it goes on.
   task automatic test_flow_control();
      gaps_on     = 1'b0;
      rx_pattern  <= RX_ALWAYS;
      hold_toggle <= ~hold_toggle;
      run_random_pairs(24);
      drain();
      gaps_on    = 1'b1;
      rx_pattern <= RX_RANDOM;
      run_random_pairs(24);
      drain();
      run_random_pairs(24);
      drain();
   endtask

   initial begin
      clear_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset      <= 1'b0;
      rx_pattern <= RX_RANDOM;
      @(posedge clock);

      test_reset_defaults();
      test_bypass_threshold();
      test_delay_extremes();
      test_random_sweep();
      test_flow_control();

      // Everything is back; give a stray extra beat time to show up.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pairs_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: stereo_allpass_diffuser.f
+incdir+rtl
rtl/sad_pkg.sv
rtl/sad_ring_mem.sv
rtl/sad_mix_unit.sv
rtl/stereo_allpass_diffuser.sv
test/tb_stereo_allpass_diffuser.sv
